[hdl/sliding_window_variance_detector_macros.svh]
// Assertion helpers for the detector's datapath.
`ifndef SLIDING_WINDOW_VARIANCE_DETECTOR_MACROS_SVH
`define SLIDING_WINDOW_VARIANCE_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWVD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWVD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/swvd_pkg.sv]
package swvd_pkg;

	localparam int WINDOW_LENGTH_DEF = 32;

	localparam int TIME_W     = 32;
	localparam int SAMPLE_W   = 16;
	localparam int STEP_W     = 16;
	localparam int VAR_W      = 32;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [STEP_W-1:0] STEP_RESET   = STEP_W'(50);
	localparam logic [VAR_W-1:0]  THRESH_RESET = VAR_W'(655);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLIDING_STEP       = CFG_IDX_W'(0),
		REG_VARIANCE_THRESHOLD = CFG_IDX_W'(1)
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM_RD,
		ST_SUM_WAIT,
		ST_SQR_RD,
		ST_SQR_WAIT,
		ST_DIV,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;      // take the sample request this cycle
		logic acc_clr;     // clear sum, square accumulator and read counter
		logic rd_en;       // issue one ring read
		logic pass_sqr;    // reads feed the square pass, else the sum pass
		logic div_load;    // clear the divider's product and step counter
		logic div_en;      // run one divider step
		logic load_result; // move the quotient into the result register
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic eval_go;   // incoming sample triggers an evaluation
		logic rd_last;   // current read is the last entry of the ring
		logic pipe_busy; // read pipeline still holds data
		logic div_last;  // current divider step is the final one
		logic res_busy;  // result register is full and not being taken
	} sts_t;

endpackage

[hdl/swvd_sample_if.sv]
interface swvd_sample_if;
	logic                          valid;
	logic                          ready;
	logic [swvd_pkg::TIME_W-1:0]   sample_time;
	logic [swvd_pkg::SAMPLE_W-1:0] accel_magnitude;

	modport source (output valid, output sample_time, output accel_magnitude, input ready);
	modport sink   (input valid, input sample_time, input accel_magnitude, output ready);
endinterface

[hdl/swvd_result_if.sv]
interface swvd_result_if;
	logic                        valid;
	logic                        ready;
	logic [swvd_pkg::TIME_W-1:0] window_end_time;
	logic [swvd_pkg::VAR_W-1:0]  window_variance;
	logic                        window_still;

	modport source (output valid, output window_end_time, output window_variance,
		output window_still, input ready);
	modport sink   (input valid, input window_end_time, input window_variance,
		input window_still, output ready);
endinterface

[hdl/swvd_cfg_if.sv]
interface swvd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [swvd_pkg::CFG_IDX_W-1:0]  index;
	logic [swvd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/sliding_window_variance_detector.sv]
// Stillness detector over a sliding window of acceleration magnitudes. Each
// sample request (timestamp in ms, magnitude in unsigned Q8.8) is written into
// a ring of WINDOW_LENGTH entries when it is accepted. Once more than
// WINDOW_LENGTH samples have arrived and the timestamp has moved on by more
// than sliding_step_ms since the last evaluation (difference taken modulo
// 2^32), the block evaluates the window: it walks the ring once to form the
// sum S, walks it again to accumulate (N*x - S)^2, and divides by N^3 by
// multiplying with a precomputed reciprocal, one 32x32 limb product per cycle
// over four steps. The result request carries the newest timestamp, the
// variance in Q16.16 (truncated) and a still flag set when the variance is
// below variance_threshold. An evaluating sample keeps the block busy through
// both ring passes and the four-step multiply; the passes run one after the
// other, set by the single read port of the ring memory. A sample that does
// not evaluate is taken without leaving the idle state. A finished result
// waits in an output register, so new samples are taken while it is pending;
// beyond an evaluation, the block only holds off when a second result is ready
// before the first was taken. The ring is not cleared after reset; warm-up
// guarantees every entry is written before it is read. Configuration writes
// are always taken and should be made while the block is idle.
module sliding_window_variance_detector #(
	parameter int WINDOW_LENGTH = swvd_pkg::WINDOW_LENGTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	swvd_sample_if.sink   sample,
	swvd_result_if.source result,
	swvd_cfg_if.sink      cfg
);

	swvd_pkg::ctl_t ctl;
	swvd_pkg::sts_t sts;
	logic           cfg_we;

	// register writes go straight into the config registers, so never stall the config channel
	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;

	// sequence the two ring passes, the divide and the result hand-off
	swvd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// ring, accumulators, divider and result register
	swvd_datapath #(
		.WINDOW_LENGTH (WINDOW_LENGTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.sample_time     (sample.sample_time),
		.accel_magnitude (sample.accel_magnitude),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.res_valid       (result.valid),
		.res_ready       (result.ready),
		.res_time        (result.window_end_time),
		.res_variance    (result.window_variance),
		.res_still       (result.window_still)
	);

endmodule

[hdl/swvd_ram.sv]
module swvd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/swvd_ctrl.sv]
module swvd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  swvd_pkg::sts_t sts,
	output swvd_pkg::ctl_t ctl
);

	swvd_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swvd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			swvd_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				ctl.accept = in_valid;
				if (in_valid && sts.eval_go) begin
					ctl.acc_clr = 1'b1;
					state_d     = swvd_pkg::ST_SUM_RD;
				end
			end
			swvd_pkg::ST_SUM_RD: begin
				ctl.rd_en = 1'b1;
				if (sts.rd_last) begin
					state_d = swvd_pkg::ST_SUM_WAIT;
				end
			end
			swvd_pkg::ST_SUM_WAIT: begin
				if (!sts.pipe_busy) begin
					state_d = swvd_pkg::ST_SQR_RD;
				end
			end
			swvd_pkg::ST_SQR_RD: begin
				ctl.rd_en    = 1'b1;
				ctl.pass_sqr = 1'b1;
				if (sts.rd_last) begin
					state_d = swvd_pkg::ST_SQR_WAIT;
				end
			end
			swvd_pkg::ST_SQR_WAIT: begin
				if (!sts.pipe_busy) begin
					ctl.div_load = 1'b1;
					state_d      = swvd_pkg::ST_DIV;
				end
			end
			swvd_pkg::ST_DIV: begin
				ctl.div_en = 1'b1;
				if (sts.div_last) begin
					state_d = swvd_pkg::ST_OUT;
				end
			end
			swvd_pkg::ST_OUT: begin
				// hold until the result slot frees up
				if (!sts.res_busy) begin
					ctl.load_result = 1'b1;
					state_d         = swvd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = swvd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[hdl/swvd_datapath.sv]
`include "sliding_window_variance_detector_macros.svh"

module swvd_datapath #(
	parameter int WINDOW_LENGTH = swvd_pkg::WINDOW_LENGTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  swvd_pkg::ctl_t                    ctl,
	output swvd_pkg::sts_t                    sts,
	input  logic [swvd_pkg::TIME_W-1:0]       sample_time,
	input  logic [swvd_pkg::SAMPLE_W-1:0]     accel_magnitude,
	input  logic                              cfg_we,
	input  logic [swvd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [swvd_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [swvd_pkg::TIME_W-1:0]       res_time,
	output logic [swvd_pkg::VAR_W-1:0]        res_variance,
	output logic                              res_still
);

	localparam int AW     = $clog2(WINDOW_LENGTH);           // ring address
	localparam int NW     = $clog2(WINDOW_LENGTH + 1);       // holds N
	localparam int SEEN_W = $clog2(WINDOW_LENGTH + 2);       // holds N+1
	localparam int SW     = swvd_pkg::SAMPLE_W + NW;         // sum and N*x
	localparam int QW     = 2 * SW + NW;                     // square accumulator
	localparam int DW     = 3 * NW;                          // N^3
	localparam logic [DW-1:0] DIVISOR =
		DW'(WINDOW_LENGTH * WINDOW_LENGTH * WINDOW_LENGTH);
	localparam logic [SW-1:0] N_MUL = SW'(WINDOW_LENGTH);

	// configuration
	logic [swvd_pkg::STEP_W-1:0] step_q;
	logic [swvd_pkg::VAR_W-1:0]  thresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= swvd_pkg::STEP_RESET;
			thresh_q <= swvd_pkg::THRESH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				swvd_pkg::REG_SLIDING_STEP:       step_q   <= cfg_data[swvd_pkg::STEP_W-1:0];
				swvd_pkg::REG_VARIANCE_THRESHOLD: thresh_q <= cfg_data[swvd_pkg::VAR_W-1:0];
				default: ;
			endcase
		end
	end

	// ring bookkeeping
	logic [AW-1:0]              wp_q;
	logic [SEEN_W-1:0]          seen_q;
	logic [swvd_pkg::TIME_W-1:0] last_eval_q;
	logic [swvd_pkg::TIME_W-1:0] end_time_q;
	logic [swvd_pkg::TIME_W-1:0] dt;

	assign dt          = sample_time - last_eval_q;
	assign sts.eval_go = (seen_q >= SEEN_W'(WINDOW_LENGTH)) &&
		(dt > swvd_pkg::TIME_W'(step_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			seen_q      <= '0;
			last_eval_q <= '0;
		end else if (ctl.accept) begin
			wp_q <= (wp_q == AW'(WINDOW_LENGTH - 1)) ? '0 : wp_q + AW'(1);
			if (seen_q < SEEN_W'(WINDOW_LENGTH + 1)) begin
				seen_q <= seen_q + SEEN_W'(1);
			end
			if (sts.eval_go) begin
				last_eval_q <= sample_time;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept && sts.eval_go) begin
			end_time_q <= sample_time;
		end
	end

	// ring memory and read pipeline
	logic [AW-1:0]                 rd_cnt_q;
	logic [swvd_pkg::SAMPLE_W-1:0] ram_rdata;
	logic                          v_s1, sqr_s1, v_s2, v_s3;
	logic [SW-1:0]                 sum_q;
	logic [SW-1:0]                 nx;
	logic [SW-1:0]                 d_s2;
	logic [2*SW-1:0]               sq_s3;
	logic [QW-1:0]                 acc_q;
	logic                          pipe_busy;

	swvd_ram #(
		.WIDTH (swvd_pkg::SAMPLE_W),
		.DEPTH (WINDOW_LENGTH)
	) u_ring (
		.clk   (clk),
		.we    (ctl.accept),
		.waddr (wp_q),
		.wdata (accel_magnitude),
		.re    (ctl.rd_en),
		.raddr (rd_cnt_q),
		.rdata (ram_rdata)
	);

	assign sts.rd_last   = (rd_cnt_q == AW'(WINDOW_LENGTH - 1));
	assign pipe_busy     = v_s1 | v_s2 | v_s3;
	assign sts.pipe_busy = pipe_busy;
	assign nx            = N_MUL * SW'(ram_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			v_s1     <= 1'b0;
			sqr_s1   <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
		end else begin
			if (ctl.acc_clr) begin
				rd_cnt_q <= '0;
			end else if (ctl.rd_en) begin
				rd_cnt_q <= sts.rd_last ? '0 : rd_cnt_q + AW'(1);
			end
			v_s1   <= ctl.rd_en;
			sqr_s1 <= ctl.pass_sqr;
			v_s2   <= v_s1 && sqr_s1;
			v_s3   <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.acc_clr) begin
			sum_q <= '0;
		end else if (v_s1 && !sqr_s1) begin
			sum_q <= sum_q + SW'(ram_rdata);
		end
		if (v_s1 && sqr_s1) begin
			d_s2 <= (nx >= sum_q) ? nx - sum_q : sum_q - nx;
		end
		if (v_s2) begin
			sq_s3 <= d_s2 * d_s2;
		end
		if (ctl.acc_clr) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= acc_q + QW'(sq_s3);
		end
	end

	// divide by N^3 as a multiply by a rounded-up reciprocal; the accumulator and
	// the reciprocal are split into 32-bit limbs and one limb product is added
	// per step, so four steps give the full product and the quotient is its top
	localparam int MW    = 64;                          // two limbs
	localparam int PW    = 2 * MW;                      // full product
	localparam int LOG_D = $clog2(WINDOW_LENGTH * WINDOW_LENGTH * WINDOW_LENGTH);
	localparam int SHIFT = QW + LOG_D;                  // exact for any QW-bit dividend
	localparam logic [PW-1:0] D_WIDE     = PW'(DIVISOR);
	localparam logic [PW-1:0] RECIP_WIDE = ((PW'(1) << SHIFT) + D_WIDE - PW'(1)) / D_WIDE;
	localparam logic [MW-1:0] RECIP      = RECIP_WIDE[MW-1:0];

	logic [MW-1:0]       acc_wide;
	logic [1:0]          mul_cnt_q;
	logic [31:0]         a_limb;
	logic [31:0]         m_limb;
	logic [MW-1:0]       pp;
	logic [1:0]          pp_pos;
	logic [PW-1:0]       pp_wide;
	logic [PW-1:0]       prod_q;
	logic [PW-SHIFT-1:0] quo;

	assign acc_wide     = MW'(acc_q);
	assign a_limb       = mul_cnt_q[1] ? acc_wide[MW-1:32] : acc_wide[31:0];
	assign m_limb       = mul_cnt_q[0] ? RECIP[MW-1:32] : RECIP[31:0];
	assign pp           = {32'b0, a_limb} * {32'b0, m_limb};
	assign pp_pos       = {1'b0, mul_cnt_q[1]} + {1'b0, mul_cnt_q[0]};
	assign sts.div_last = (mul_cnt_q == 2'd3);

	always_comb begin
		case (pp_pos)
			2'd0:    pp_wide = {64'b0, pp};
			2'd1:    pp_wide = {32'b0, pp, 32'b0};
			default: pp_wide = {pp, 64'b0};
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.div_load) begin
			prod_q    <= '0;
			mul_cnt_q <= '0;
		end else if (ctl.div_en) begin
			prod_q    <= prod_q + pp_wide;
			mul_cnt_q <= mul_cnt_q + 2'd1;
		end
	end

	// result register
	logic [swvd_pkg::VAR_W-1:0] variance;
	logic                       res_valid_q;

	assign quo          = prod_q[PW-1:SHIFT];
	assign variance     = (|quo[PW-SHIFT-1:swvd_pkg::VAR_W]) ? '1 : quo[swvd_pkg::VAR_W-1:0];
	assign sts.res_busy = res_valid_q && !res_ready;
	assign res_valid    = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.load_result) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_result) begin
			res_time     <= end_time_q;
			res_variance <= variance;
			res_still    <= (variance < thresh_q);
		end
	end

	`SWVD_ASSERT_NOW(a_div_after_drain, clk, arst_n, ctl.div_load || ctl.div_en, !pipe_busy, "divider ran while the read pipeline held data")
	`SWVD_ASSERT_NOW(a_load_slot_free, clk, arst_n, ctl.load_result, !res_valid_q || res_ready, "result overwritten before it was taken")
	`SWVD_ASSERT_NOW(a_quotient_fits, clk, arst_n, ctl.load_result, quo[PW-SHIFT-1:swvd_pkg::VAR_W] == '0, "variance quotient exceeded 32 bits")
	`SWVD_ASSERT_NOW(a_wp_in_range, clk, arst_n, 1'b1, wp_q <= AW'(WINDOW_LENGTH - 1), "ring write pointer left the window")
	`SWVD_ASSERT_NEXT(a_sum_before_sqr, clk, arst_n, ctl.acc_clr, !v_s2 && !v_s3, "square pass overlapped a new evaluation")

endmodule

[sim/swvd_window_checker.sv]
module swvd_window_checker
	import swvd_pkg::*;
#(
	parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	swvd_sample_if sample,
	swvd_result_if result,
	swvd_cfg_if    cfg,
	output int     errors,
	output int     outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [TIME_W-1:0] end_time;
		logic [VAR_W-1:0]  variance;
		logic              still;
	} window_result_t;

	logic [SAMPLE_W-1:0] magnitudes [WINDOW_LENGTH];
	int unsigned         write_slot;
	int unsigned         filled;
	logic [TIME_W-1:0]   last_eval_ms;
	logic [STEP_W-1:0]   step_ms;
	logic [VAR_W-1:0]    still_limit;
	window_result_t      pending_windows [$];

	// Exact population variance of the ring: sum((N*x - S)^2) / N^3, truncated.
	function automatic logic [VAR_W-1:0] variance_of_ring();
		longint unsigned total;
		longint unsigned sq_acc;
		longint unsigned scaled;
		longint unsigned dev;
		longint unsigned cube;
		longint unsigned quot;
		total  = 0;
		sq_acc = 0;
		foreach (magnitudes[k])
			total += magnitudes[k];
		foreach (magnitudes[k]) begin
			scaled = magnitudes[k];
			scaled = scaled * WINDOW_LENGTH;
			dev    = (scaled >= total) ? scaled - total : total - scaled;
			sq_acc += dev * dev;
		end
		cube = WINDOW_LENGTH;
		cube = cube * cube * cube;
		quot = sq_acc / cube;
		if (quot > 64'hFFFF_FFFF)
			quot = 64'hFFFF_FFFF;
		return VAR_W'(quot);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		window_result_t due;
		window_result_t got;
		logic [TIME_W-1:0] stamp;
		if (!arst_n) begin
			foreach (magnitudes[k])
				magnitudes[k] = '0;
			write_slot   = 0;
			filled       = 0;
			last_eval_ms = '0;
			step_ms      = STEP_RESET;
			still_limit  = THRESH_RESET;
			pending_windows.delete();
			errors       = 0;
			outstanding <= 0;
		end else begin
			// Retire results first: none can stem from a sample taken at this same edge.
			if (result.valid && result.ready) begin
				got.end_time = result.window_end_time;
				got.variance = result.window_variance;
				got.still    = result.window_still;
				if (pending_windows.size() == 0) begin
					$error("window result at %0d with no evaluation pending", got.end_time);
					errors++;
				end else begin
					due = pending_windows.pop_front();
					if (got.end_time !== due.end_time) begin
						$error("window_end_time: expected %0d, actual %0d",
							due.end_time, got.end_time);
						errors++;
					end
					if (got.variance !== due.variance) begin
						$error("window_variance: expected %0d, actual %0d",
							due.variance, got.variance);
						errors++;
					end
					if (got.still !== due.still) begin
						$error("window_still: expected %0b, actual %0b", due.still, got.still);
						errors++;
					end
				end
			end

			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_SLIDING_STEP:       step_ms = cfg.data[STEP_W-1:0];
					REG_VARIANCE_THRESHOLD: still_limit = cfg.data[VAR_W-1:0];
					default: ; // unmapped index: drop the write
				endcase
			end

			if (sample.valid && sample.ready) begin
				stamp = sample.sample_time;
				magnitudes[write_slot] = sample.accel_magnitude;
				write_slot = (write_slot + 1) % WINDOW_LENGTH;
				if (filled <= WINDOW_LENGTH)
					filled++;
				if (filled > WINDOW_LENGTH && TIME_W'(stamp - last_eval_ms) > step_ms) begin
					due.end_time = stamp;
					due.variance = variance_of_ring();
					due.still    = (due.variance < still_limit);
					pending_windows.push_back(due);
					last_eval_ms = stamp;
				end
			end

			outstanding <= pending_windows.size();
		end
	end

endmodule

[sim/tb_sliding_window_variance_detector.sv]
module tb_sliding_window_variance_detector;
	timeunit 1ns;
	timeprecision 1ps;

	import swvd_pkg::*;

	localparam int WINDOW_LENGTH   = WINDOW_LENGTH_DEF;
	// One evaluation walks the ring twice and runs the divide.
	localparam int SETTLE_CYCLES   = 160;
	localparam int LONG_HOLD       = 3000;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int MAG_TOP         = (1 << SAMPLE_W) - 1;
	localparam int REG_UNMAPPED_LO = int'(REG_VARIANCE_THRESHOLD) + 1;
	localparam int REG_UNMAPPED_HI = (1 << CFG_IDX_W) - 1;

	typedef enum int {
		MAG_FLAT_NOISE,
		MAG_FULL_RANDOM,
		MAG_EXTREMES
	} magnitude_mode_t;

	logic clk;
	logic arst_n;

	swvd_sample_if sample_ch ();
	swvd_result_if result_ch ();
	swvd_cfg_if    cfg_ch ();

	int errors;
	int outstanding;

	// Stimulus state: current timestamp, mirrored step for shaping, idling knobs.
	logic [TIME_W-1:0]   now_ms;
	logic [STEP_W-1:0]   cur_step;
	int                  gap_rate;
	int                  stall_rate;
	logic                long_hold_armed;
	logic                hold_taken;
	magnitude_mode_t     mag_mode;
	logic [SAMPLE_W-1:0] mag_base;
	int                  mag_spread;
	int                  regime_left;
	int                  cycle_count;

	sliding_window_variance_detector #(
		.WINDOW_LENGTH(WINDOW_LENGTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch),
		.cfg   (cfg_ch)
	);

	swvd_window_checker #(
		.WINDOW_LENGTH(WINDOW_LENGTH)
	) u_window_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample_ch),
		.result     (result_ch),
		.cfg        (cfg_ch),
		.errors     (errors),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: end the run as a failure if it is still going at the cycle limit.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// Result side: random ready bursts, plus one long hold-off when armed so the
	// output register fills and the block has to stall its sample input.
	initial begin
		logic ready_level;
		int   span;
		result_ch.ready <= 1'b0;
		hold_taken = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (long_hold_armed && !hold_taken) begin
				hold_taken  = 1'b1;
				ready_level = 1'b0;
				span        = LONG_HOLD;
			end else if (stall_rate > 0 && $urandom_range(0, 99) < stall_rate) begin
				ready_level = 1'b0;
				span        = $urandom_range(1, 16);
			end else begin
				ready_level = 1'b1;
				span        = $urandom_range(1, 16);
			end
			result_ch.ready <= ready_level;
			repeat (span) @(posedge clk);
		end
	end

	// Next timestamp: mostly small creeps and steps right around the step
	// register, with occasional wild jumps, stalls and backward moves.
	function automatic logic [TIME_W-1:0] next_stamp(input logic [TIME_W-1:0] prev,
			input logic [STEP_W-1:0] step);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			return prev + TIME_W'($urandom_range(0, step / 8 + 1));
		else if (pick < 75)
			return prev + TIME_W'(step) + TIME_W'($urandom_range(0, 2));
		else if (pick < 88)
			return prev + TIME_W'($urandom());
		else if (pick < 94)
			return prev;
		else
			return prev - TIME_W'($urandom_range(1, 100));
	endfunction

	function automatic logic [SAMPLE_W-1:0] draw_magnitude();
		int level;
		case (mag_mode)
			MAG_FULL_RANDOM: return SAMPLE_W'($urandom());
			MAG_EXTREMES:    return $urandom_range(0, 1) ? {SAMPLE_W{1'b1}} : {SAMPLE_W{1'b0}};
			default: begin
				level = int'(mag_base) + int'($urandom_range(0, 2 * mag_spread)) - mag_spread;
				if (level < 0)
					level = 0;
				if (level > MAG_TOP)
					level = MAG_TOP;
				return SAMPLE_W'(level);
			end
		endcase
	endfunction

	// Offer one sample request, optionally after a random gap, and hold it
	// until the block takes it. Valid stays high on return.
	task automatic push_sample(input logic [TIME_W-1:0] stamp, input logic [SAMPLE_W-1:0] mag);
		if (gap_rate > 0 && $urandom_range(0, 99) < gap_rate) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		sample_ch.valid           <= 1'b1;
		sample_ch.sample_time     <= stamp;
		sample_ch.accel_magnitude <= mag;
		do @(posedge clk); while (!sample_ch.ready);
		now_ms = stamp;
	endtask

	// Random samples in regimes of 20..60 items, so flat windows (zero or tiny
	// variance) and wild windows can both fill the whole ring.
	task automatic stream_samples(input int count);
		for (int i = 0; i < count; i++) begin
			if (regime_left == 0) begin
				regime_left = $urandom_range(20, 60);
				mag_base    = SAMPLE_W'($urandom());
				case ($urandom_range(0, 6))
					0:       mag_mode = MAG_FULL_RANDOM;
					1:       mag_mode = MAG_EXTREMES;
					default: mag_mode = MAG_FLAT_NOISE;
				endcase
				case ($urandom_range(0, 4))
					0:       mag_spread = 0;
					1:       mag_spread = 4;
					2:       mag_spread = 24;
					3:       mag_spread = 96;
					default: mag_spread = 1024;
				endcase
			end
			regime_left--;
			push_sample(next_stamp(now_ms, cur_step), draw_magnitude());
		end
	endtask

	// Write one register. Valid stays high so writes can go back to back; the
	// caller drops it after the last one.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_SLIDING_STEP)
			cur_step = value[STEP_W-1:0];
	endtask

	// Drop valid, wait for every expected window, then let any sample that
	// cannot produce a result finish before touching the registers.
	task automatic settle_block();
		sample_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		// Known values on every input from time zero.
		arst_n                    <= 1'b0;
		sample_ch.valid           <= 1'b0;
		sample_ch.sample_time     <= '0;
		sample_ch.accel_magnitude <= '0;
		cfg_ch.valid              <= 1'b0;
		cfg_ch.index              <= '0;
		cfg_ch.data               <= '0;
		long_hold_armed           <= 1'b0;
		stall_rate                <= 25;
		gap_rate    = 25;
		now_ms      = '0;
		cur_step    = STEP_RESET;
		regime_left = 0;
		mag_mode    = MAG_FLAT_NOISE;
		mag_base    = '0;
		mag_spread  = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset registers. Warm-up: alternate the magnitude extremes; nothing may
		// come out before the ring has seen more than a full window, even with a
		// large timestamp jump on the last warm-up sample.
		for (int k = 1; k < WINDOW_LENGTH; k++)
			push_sample(TIME_W'(k), (k % 2) ? {SAMPLE_W{1'b1}} : {SAMPLE_W{1'b0}});
		push_sample(32'd1000, {SAMPLE_W{1'b0}});
		push_sample(32'd1050, {SAMPLE_W{1'b1}});   // first evaluation right after warm-up
		push_sample(32'd1100, {SAMPLE_W{1'b0}});   // advance equals the step: none
		push_sample(32'd1101, {SAMPLE_W{1'b1}});   // one past the step: evaluate
		push_sample(32'd1101, {SAMPLE_W{1'b0}});   // timestamp stands still
		push_sample(32'd1000, {SAMPLE_W{1'b1}});   // backwards: wraps to a huge advance
		push_sample(32'hFFFF_FFF0, 16'h8000);
		push_sample(32'h0000_0030, 16'h7FFF);      // advance across the 2^32 wrap
		settle_block();

		// Step zero, threshold zero; unmapped indexes must leave both alone.
		write_register(REG_SLIDING_STEP, '0);
		write_register(REG_VARIANCE_THRESHOLD, '0);
		write_register(CFG_IDX_W'(REG_UNMAPPED_LO), $urandom());
		write_register(CFG_IDX_W'(REG_UNMAPPED_HI), $urandom());
		cfg_ch.valid <= 1'b0;
		push_sample(now_ms + 32'd7, 16'h0100);
		push_sample(now_ms, 16'h0100);             // no advance with step zero: none
		push_sample(now_ms + 32'd1, 16'h0101);     // any advance at all: evaluate
		stream_samples(200);
		settle_block();

		// Largest step, largest threshold: every window reads as still.
		stall_rate <= 50;
		write_register(REG_SLIDING_STEP, {STEP_W{1'b1}});
		write_register(REG_VARIANCE_THRESHOLD, {VAR_W{1'b1}});
		cfg_ch.valid <= 1'b0;
		push_sample(now_ms + 32'h0001_0000, 16'h1234);
		push_sample(now_ms + 32'h0000_FFFF, 16'h4321);
		push_sample(now_ms + 32'd1, 16'hABCD);
		stream_samples(150);
		settle_block();

		// Moderate random settings with sparse idling.
		stall_rate <= 10;
		gap_rate = 10;
		write_register(REG_SLIDING_STEP, $urandom_range(0, 255));
		write_register(REG_VARIANCE_THRESHOLD, $urandom() >> $urandom_range(0, 31));
		write_register(CFG_IDX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)), $urandom());
		cfg_ch.valid <= 1'b0;
		stream_samples(250);
		settle_block();

		// Back-pressure: every sample whose timestamp changes evaluates while the result
		// side holds off, so the block must stall its input with a finished window pending.
		gap_rate = 0;
		write_register(REG_SLIDING_STEP, '0);
		write_register(REG_VARIANCE_THRESHOLD, $urandom() >> $urandom_range(0, 31));
		cfg_ch.valid <= 1'b0;
		long_hold_armed <= 1'b1;
		stream_samples(150);
		settle_block();

		// Two random settings, one with an arbitrary step over the full range.
		gap_rate = 30;
		stall_rate <= 30;
		write_register(REG_SLIDING_STEP, $urandom_range(0, 300));
		write_register(REG_VARIANCE_THRESHOLD, $urandom() >> $urandom_range(0, 31));
		cfg_ch.valid <= 1'b0;
		stream_samples(150);
		settle_block();

		write_register(REG_SLIDING_STEP, $urandom_range(0, MAG_TOP));
		write_register(REG_VARIANCE_THRESHOLD, $urandom());
		cfg_ch.valid <= 1'b0;
		stream_samples(150);
		settle_block();

		// Tail: no idling on either side, full rate.
		gap_rate = 0;
		stall_rate <= 0;
		write_register(REG_SLIDING_STEP, 32'd20);
		write_register(REG_VARIANCE_THRESHOLD, 32'd2000);
		cfg_ch.valid <= 1'b0;
		stream_samples(120);
		settle_block();

		if (errors == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[sliding_window_variance_detector.f]
+incdir+hdl
hdl/swvd_pkg.sv
hdl/swvd_sample_if.sv
hdl/swvd_result_if.sv
hdl/swvd_cfg_if.sv
hdl/swvd_ram.sv
hdl/swvd_ctrl.sv
hdl/swvd_datapath.sv
hdl/sliding_window_variance_detector.sv
sim/swvd_window_checker.sv
sim/tb_sliding_window_variance_detector.sv
